// ===== src/su2slp_pkg.sv =====
// ----------------------------------------------------------------------------
// su2slp_pkg
// Shared types, widths and tables of the SU(2) staple link projection block.
// ----------------------------------------------------------------------------
package su2slp_pkg;

  localparam int SPACE_EXTENT_DEF = 16;
  localparam int TIME_EXTENT_DEF  = 8;

  localparam int FRAC_BITS  = 16;
  localparam int LINK_W     = FRAC_BITS + 2;
  localparam int QX_W       = LINK_W + 2;
  localparam int SUM_W      = LINK_W + 6;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int SQ_W       = PROD_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int QUO_W      = FRAC_BITS + 2;
  localparam int NUM_W      = SUM_W + FRAC_BITS;
  localparam int CNT_W      = 5;
  localparam int ONE_FX     = 1 << FRAC_BITS;

  typedef logic [LINK_W-1:0] comp_t;
  typedef comp_t [3:0] link_t;

  localparam logic signed [LINK_W-1:0] ONE_LINK = LINK_W'(ONE_FX);
  localparam link_t IDENTITY_LINK = {comp_t'(0), comp_t'(0), comp_t'(0), comp_t'(ONE_FX)};

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_MIN   = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_TAKE,
    ST_LD_ADDR,
    ST_LD_WAIT,
    ST_LD_TAKE,
    ST_MUL1,
    ST_MUL2,
    ST_DRAIN,
    ST_SQ,
    ST_SQ_DRAIN,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_ROOT_DONE,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_STORE,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_e;

  typedef enum logic [1:0] {
    DST_X,
    DST_SUM,
    DST_SQ
  } dst_e;

  typedef struct packed {
    step_e mu_step;
    step_e nu_step;
    logic  on_nu;
    logic  conj;
  } ld_sel_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } qterm_t;

  // staple factors: first triple then second triple of one plane
  function automatic ld_sel_t ld_sel(logic [2:0] idx);
    ld_sel_t r;
    case (idx)
      3'd0:    r = '{mu_step: STEP_UP,   nu_step: STEP_NONE, on_nu: 1'b1, conj: 1'b0};
      3'd1:    r = '{mu_step: STEP_NONE, nu_step: STEP_UP,   on_nu: 1'b0, conj: 1'b1};
      3'd2:    r = '{mu_step: STEP_NONE, nu_step: STEP_NONE, on_nu: 1'b1, conj: 1'b1};
      3'd3:    r = '{mu_step: STEP_UP,   nu_step: STEP_DOWN, on_nu: 1'b1, conj: 1'b1};
      3'd4:    r = '{mu_step: STEP_NONE, nu_step: STEP_DOWN, on_nu: 1'b0, conj: 1'b1};
      default: r = '{mu_step: STEP_NONE, nu_step: STEP_DOWN, on_nu: 1'b1, conj: 1'b0};
    endcase
    return r;
  endfunction

  // one partial product of a quaternion product, four per component
  function automatic qterm_t qterm(logic [3:0] s);
    qterm_t r;
    case (s)
      4'd0:    r = '{ai: 2'd0, bi: 2'd0, neg: 1'b0};
      4'd1:    r = '{ai: 2'd1, bi: 2'd1, neg: 1'b1};
      4'd2:    r = '{ai: 2'd2, bi: 2'd2, neg: 1'b1};
      4'd3:    r = '{ai: 2'd3, bi: 2'd3, neg: 1'b1};
      4'd4:    r = '{ai: 2'd0, bi: 2'd1, neg: 1'b0};
      4'd5:    r = '{ai: 2'd1, bi: 2'd0, neg: 1'b0};
      4'd6:    r = '{ai: 2'd2, bi: 2'd3, neg: 1'b1};
      4'd7:    r = '{ai: 2'd3, bi: 2'd2, neg: 1'b0};
      4'd8:    r = '{ai: 2'd0, bi: 2'd2, neg: 1'b0};
      4'd9:    r = '{ai: 2'd2, bi: 2'd0, neg: 1'b0};
      4'd10:   r = '{ai: 2'd3, bi: 2'd1, neg: 1'b1};
      4'd11:   r = '{ai: 2'd1, bi: 2'd3, neg: 1'b0};
      4'd12:   r = '{ai: 2'd0, bi: 2'd3, neg: 1'b0};
      4'd13:   r = '{ai: 2'd3, bi: 2'd0, neg: 1'b0};
      4'd14:   r = '{ai: 2'd1, bi: 2'd2, neg: 1'b1};
      default: r = '{ai: 2'd2, bi: 2'd1, neg: 1'b0};
    endcase
    return r;
  endfunction

  function automatic link_t conj_link(link_t v);
    link_t r;
    r[0] = v[0];
    r[1] = -v[1];
    r[2] = -v[2];
    r[3] = -v[3];
    return r;
  endfunction

  function automatic comp_t sat_comp(logic signed [LINK_W-1:0] v);
    comp_t r;
    r = comp_t'(v);
    if (v > ONE_LINK) r = comp_t'(ONE_LINK);
    if (v < -ONE_LINK) r = comp_t'(-ONE_LINK);
    return r;
  endfunction

endpackage

// ===== src/su2slp_link_ram.sv =====
// ----------------------------------------------------------------------------
// su2slp_link_ram
// Single write port, single registered read port link memory.
// ----------------------------------------------------------------------------
module su2slp_link_ram
  import su2slp_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  link_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output link_t         rdata_o
);

  link_t mem [DEPTH];
  link_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/su2_staple_link_projection.sv =====
// ----------------------------------------------------------------------------
// su2_staple_link_projection
// SU(2) link store on a periodic 4D lattice with staple projection update.
// ----------------------------------------------------------------------------
// Holds SPACE_EXTENT^3 x TIME_EXTENT sites with four Q1.16 quaternion links
// each, in one RAM with one write and one registered read port. After reset
// the block sweeps the RAM to the identity link, one link per cycle, and
// takes no word meanwhile. A word then writes, reads or minimizes one link
// and gives one result word; the block takes one word at a time. A minimize
// makes eighteen RAM reads and 196 passes through the one 24x24 multiplier,
// then a bit-serial square root of 24 steps and four bit-serial divides;
// with a zero staple norm it skips the divides and returns the stored link
// with status set. A result word that is not taken holds the block before
// its next word.
// ----------------------------------------------------------------------------
module su2_staple_link_projection
  import su2slp_pkg::*;
#(
  parameter int SPACE_EXTENT = SPACE_EXTENT_DEF,
  parameter int TIME_EXTENT  = TIME_EXTENT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_pos, y_pos, z_pos, t_pos, link_dir, w_real, w_i, w_j, w_k, zero fill
  input  logic [95:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // q_real, q_i, q_j, q_k
  output logic [71:0] m_axis_tdata,
  // status
  output logic [0:0]  m_axis_tuser
);

  localparam int SB        = $clog2(SPACE_EXTENT);
  localparam int TB        = $clog2(TIME_EXTENT);
  localparam int NUM_LINKS = SPACE_EXTENT * SPACE_EXTENT * SPACE_EXTENT * TIME_EXTENT * 4;
  localparam int AW        = $clog2(NUM_LINKS);
  localparam int CW        = 7;
  localparam int OFF_W     = 17;

  function automatic logic [CW-1:0] reduce(logic [CW-1:0] v, int e);
    logic [CW-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= CW'(e)) r = r - CW'(e);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] wrap_step(logic [CW-1:0] c, int e, step_e s);
    logic [CW-1:0] r;
    case (s)
      STEP_UP:   r = (c == CW'(e - 1)) ? '0 : c + CW'(1);
      STEP_DOWN: r = (c == '0) ? CW'(e - 1) : c - CW'(1);
      default:   r = c;
    endcase
    return r;
  endfunction

  function automatic logic [AW-1:0] link_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic [CW-1:0] z, logic [CW-1:0] t,
                                              logic [1:0] d);
    logic [AW-1:0] a;
    a = AW'(x);
    a = a * AW'(SPACE_EXTENT) + AW'(y);
    a = a * AW'(SPACE_EXTENT) + AW'(z);
    a = a * AW'(TIME_EXTENT) + AW'(t);
    a = (a << 2) | AW'(d);
    return a;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] home_q, home_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [SB-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [TB-1:0] pt_q, pt_d;
  logic [1:0] mu_q, mu_d, nuc_q, nuc_d, ld_q, ld_d, comp_q, comp_d;
  logic half_q, half_d;
  logic [3:0] step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  link_t qa_q, qa_d, qb_q, qb_d, res_q, res_d;
  logic [3:0][QX_W-1:0] qx_q, qx_d;
  logic [3:0][SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0] sq_q, sq_d, rv_q, rv_d, root_q, root_d, bit_q, bit_d;
  logic [ROOT_W-1:0] n_q, n_d, rem_q, rem_d;
  logic [QUO_W-1:0] numlo_q, numlo_d, quo_q, quo_d;
  logic status_q, status_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic pv_q, pv_d, pneg_q, pneg_d;
  dst_e pdst_q, pdst_d;
  logic [1:0] pcomp_q, pcomp_d;
  logic mv_q, mv_d;
  link_t mout_q, mout_d;
  logic mstat_q, mstat_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  link_t ram_wdata, rdata;

  logic [1:0] nu_w;
  ld_sel_t sel;
  logic [CW-1:0] base [4];
  logic [CW-1:0] nb [4];
  logic [AW-1:0] ld_addr;
  qterm_t qt;
  logic signed [SUM_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] rnd, term;
  logic [CW-1:0] rx, ry, rz, rt;
  logic [SQ_W-1:0] trial;
  logic [ROOT_W:0] r2;
  logic signed [SUM_W-1:0] sv;
  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] num;
  comp_t qval;

  su2slp_link_ram #(
    .DEPTH(NUM_LINKS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    nu_w = (nuc_q < mu_q) ? nuc_q : nuc_q + 2'd1;
    sel = ld_sel(half_q ? 3'(ld_q) + 3'd3 : 3'(ld_q));
    base[0] = CW'(px_q);
    base[1] = CW'(py_q);
    base[2] = CW'(pz_q);
    base[3] = CW'(pt_q);
    for (int d = 0; d < 4; d++) begin
      nb[d] = base[d];
      if (2'(d) == mu_q) begin
        nb[d] = wrap_step(base[d], (d == 3) ? TIME_EXTENT : SPACE_EXTENT, sel.mu_step);
      end else if (2'(d) == nu_w) begin
        nb[d] = wrap_step(base[d], (d == 3) ? TIME_EXTENT : SPACE_EXTENT, sel.nu_step);
      end
    end
    ld_addr = link_addr(nb[0], nb[1], nb[2], nb[3], sel.on_nu ? nu_w : mu_q);
    rx = reduce(CW'(s_axis_tdata[3:0]), SPACE_EXTENT);
    ry = reduce(CW'(s_axis_tdata[7:4]), SPACE_EXTENT);
    rz = reduce(CW'(s_axis_tdata[11:8]), SPACE_EXTENT);
    rt = reduce(CW'(s_axis_tdata[14:12]), TIME_EXTENT);
    qt = qterm(step_q);
    rnd = prod_q + $signed(PROD_W'(1) << (FRAC_BITS - 1));
    term = pneg_q ? -(rnd >>> FRAC_BITS) : (rnd >>> FRAC_BITS);
    trial = root_q + bit_q;
    r2 = {rem_q, numlo_q[QUO_W-1]};
    sv = $signed(sum_q[comp_q]);
    mag = (sv < 0) ? SUM_W'(-sv) : SUM_W'(sv);
    num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(n_q >> 1);
    qval = comp_t'(quo_q);
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    home_d = home_q;
    rd_addr_d = rd_addr_q;
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    pt_d = pt_q;
    mu_d = mu_q;
    nuc_d = nuc_q;
    ld_d = ld_q;
    comp_d = comp_q;
    half_d = half_q;
    step_d = step_q;
    cnt_d = cnt_q;
    qa_d = qa_q;
    qb_d = qb_q;
    res_d = res_q;
    qx_d = qx_q;
    sum_d = sum_q;
    sq_d = sq_q;
    rv_d = rv_q;
    root_d = root_q;
    bit_d = bit_q;
    n_d = n_q;
    rem_d = rem_q;
    numlo_d = numlo_q;
    quo_d = quo_q;
    status_d = status_q;
    pv_d = 1'b0;
    pneg_d = pneg_q;
    pdst_d = pdst_q;
    pcomp_d = pcomp_q;
    mv_d = mv_q & ~m_axis_tready;
    mout_d = mout_q;
    mstat_d = mstat_q;
    mul_a = '0;
    mul_b = '0;
    ram_we = 1'b0;
    ram_waddr = home_q;
    ram_wdata = res_q;
    s_axis_tready = 1'b0;

    if (pv_q) begin
      case (pdst_q)
        DST_X:   qx_d[pcomp_q] = qx_q[pcomp_q] + term[QX_W-1:0];
        DST_SUM: sum_d[pcomp_q] = sum_q[pcomp_q] + term[SUM_W-1:0];
        DST_SQ:  sq_d = sq_q + prod_q[SQ_W-1:0];
        default: sq_d = sq_q;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = IDENTITY_LINK;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_LINKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          px_d = rx[SB-1:0];
          py_d = ry[SB-1:0];
          pz_d = rz[SB-1:0];
          pt_d = rt[TB-1:0];
          mu_d = s_axis_tdata[16:15];
          home_d = link_addr(rx, ry, rz, rt, s_axis_tdata[16:15]);
          status_d = 1'b0;
          nuc_d = '0;
          half_d = 1'b0;
          ld_d = '0;
          sum_d = '0;
          case (s_axis_tuser)
            ACT_WRITE: begin
              for (int k = 0; k < 4; k++) begin
                res_d[k] = sat_comp($signed(s_axis_tdata[OFF_W + k*LINK_W +: LINK_W]));
              end
              state_d = ST_STORE;
            end
            ACT_MIN: state_d = ST_LD_ADDR;
            default: begin
              rd_addr_d = link_addr(rx, ry, rz, rt, s_axis_tdata[16:15]);
              state_d = ST_RD_WAIT;
            end
          endcase
        end
      end
      ST_RD_WAIT: state_d = ST_RD_TAKE;
      ST_RD_TAKE: begin
        res_d = rdata;
        state_d = ST_RESP;
      end
      ST_LD_ADDR: begin
        rd_addr_d = ld_addr;
        state_d = ST_LD_WAIT;
      end
      ST_LD_WAIT: state_d = ST_LD_TAKE;
      ST_LD_TAKE: begin
        step_d = '0;
        if (ld_q == 2'd0) begin
          qa_d = sel.conj ? conj_link(rdata) : rdata;
          qx_d = '0;
          ld_d = 2'd1;
          state_d = ST_LD_ADDR;
        end else if (ld_q == 2'd1) begin
          qb_d = sel.conj ? conj_link(rdata) : rdata;
          state_d = ST_MUL1;
        end else begin
          qb_d = sel.conj ? conj_link(rdata) : rdata;
          state_d = ST_MUL2;
        end
      end
      ST_MUL1: begin
        mul_a = SUM_W'($signed(qa_q[qt.ai]));
        mul_b = SUM_W'($signed(qb_q[qt.bi]));
        pv_d = 1'b1;
        pdst_d = DST_X;
        pcomp_d = step_q[3:2];
        pneg_d = qt.neg;
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          ld_d = 2'd2;
          state_d = ST_LD_ADDR;
        end
      end
      ST_MUL2: begin
        mul_a = SUM_W'($signed(qx_q[qt.ai]));
        mul_b = SUM_W'($signed(qb_q[qt.bi]));
        pv_d = 1'b1;
        pdst_d = DST_SUM;
        pcomp_d = step_q[3:2];
        pneg_d = qt.neg;
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          ld_d = '0;
          if (!half_q) begin
            half_d = 1'b1;
            state_d = ST_LD_ADDR;
          end else if (nuc_q == 2'd2) begin
            state_d = ST_DRAIN;
          end else begin
            half_d = 1'b0;
            nuc_d = nuc_q + 2'd1;
            state_d = ST_LD_ADDR;
          end
        end
      end
      ST_DRAIN: begin
        sq_d = '0;
        step_d = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        mul_a = $signed(sum_q[step_q[1:0]]);
        mul_b = $signed(sum_q[step_q[1:0]]);
        pv_d = 1'b1;
        pdst_d = DST_SQ;
        step_d = step_q + 4'd1;
        if (step_q == 4'd3) state_d = ST_SQ_DRAIN;
      end
      ST_SQ_DRAIN: state_d = ST_ROOT_INIT;
      ST_ROOT_INIT: begin
        rv_d = sq_q;
        root_d = '0;
        bit_d = SQ_W'(1) << (SQ_W - 2);
        cnt_d = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (rv_q >= trial) begin
          rv_d = rv_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = ST_ROOT_DONE;
      end
      ST_ROOT_DONE: begin
        n_d = root_q[ROOT_W-1:0];
        comp_d = '0;
        if (root_q == '0) begin
          status_d = 1'b1;
          rd_addr_d = home_q;
          state_d = ST_RD_WAIT;
        end else begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        rem_d = ROOT_W'(num >> QUO_W);
        numlo_d = num[QUO_W-1:0];
        quo_d = '0;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (r2 >= {1'b0, n_q}) begin
          rem_d = ROOT_W'(r2 - {1'b0, n_q});
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = r2[ROOT_W-1:0];
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        numlo_d = numlo_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        res_d[comp_q] = (sv[SUM_W-1] ^ (comp_q != 2'd0)) ? -qval : qval;
        comp_d = comp_q + 2'd1;
        state_d = (comp_q == 2'd3) ? ST_STORE : ST_DIV_INIT;
      end
      ST_STORE: begin
        ram_we = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          mout_d = res_q;
          mstat_d = status_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    prod_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      pv_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pv_q <= pv_d;
      mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    home_q <= home_d;
    rd_addr_q <= rd_addr_d;
    px_q <= px_d;
    py_q <= py_d;
    pz_q <= pz_d;
    pt_q <= pt_d;
    mu_q <= mu_d;
    nuc_q <= nuc_d;
    ld_q <= ld_d;
    comp_q <= comp_d;
    half_q <= half_d;
    step_q <= step_d;
    cnt_q <= cnt_d;
    qa_q <= qa_d;
    qb_q <= qb_d;
    res_q <= res_d;
    qx_q <= qx_d;
    sum_q <= sum_d;
    sq_q <= sq_d;
    rv_q <= rv_d;
    root_q <= root_d;
    bit_q <= bit_d;
    n_q <= n_d;
    rem_q <= rem_d;
    numlo_q <= numlo_d;
    quo_q <= quo_d;
    status_q <= status_d;
    prod_q <= prod_d;
    pneg_q <= pneg_d;
    pdst_q <= pdst_d;
    pcomp_q <= pcomp_d;
    mout_q <= mout_d;
    mstat_q <= mstat_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mout_q;
  assign m_axis_tuser  = mstat_q;

endmodule
